// ===== src/bia_pkg.sv =====
// Shared types and constants of the bitmap id allocator.
`default_nettype none

package bia_pkg;

  localparam int COUNT_W  = 11;
  localparam int NUM_W    = 10;
  localparam int STATUS_W = 2;

  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [NUM_W-1:0]    num_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam count_t COUNT_RESET = 11'd1024;
  localparam count_t COUNT_MAX   = {COUNT_W{1'b1}};

  // request kinds
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // result codes
  localparam status_t ST_DONE     = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_RANGE    = 2'd2;
  localparam status_t ST_WAS_FREE = 2'd3;

endpackage

`default_nettype wire

// ===== src/bia_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
`default_nettype none

module bia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [AW-1:0]            raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== src/bitmap_id_allocator.sv =====
// Bitmap id allocator: top level with the slot scanner and the request control.
//
// Hands out and takes back numbers 0 .. count-1, tracked by a bitmap of used
// numbers held in a RAM of SLOTS words of SLOT_BITS bits (number n sits in
// the slot that covers it, at its offset inside that slot). A request is taken
// when start is high and busy is low. An allocate request walks the slot words
// from slot 0, one RAM read per cycle, and grants the lowest clear bit, or
// answers "none free" if that bit is at or above the count or all bits are
// set. A release request at or above the count answers "out of range" in the
// cycle after it is taken; otherwise the scanner walks to the slot that holds
// the number, then clears its bit or answers "already free". Each result is
// shown for exactly one cycle on out_strobe and must be taken then: the
// receiver cannot stall. busy is low again in the cycle the result is shown,
// so the next request may be taken right away. The map clears at reset
// through one valid bit per slot; no sweep is needed.
// Write cfg_data (the count) only while busy is low.
`default_nettype none

module bitmap_id_allocator
  import bia_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int SLOT_BITS = 64
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            in_action,
  input  wire logic [NUM_W-1:0] in_number,
  output logic                 out_strobe,
  output logic [STATUS_W-1:0]  out_status,
  output logic [NUM_W-1:0]     out_granted,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_data
);

  localparam int TOTAL = SLOTS * SLOT_BITS;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;   // slot index
  localparam int BIW   = $clog2(SLOT_BITS);                 // bit offset in a slot
  localparam int BW    = $clog2(TOTAL + 1);                 // slot base number
  localparam int CW    = ((BW > COUNT_W) ? BW : COUNT_W) + 1; // compare width
  localparam count_t TOTAL_CAP = (TOTAL > int'(COUNT_MAX)) ? COUNT_MAX : count_t'(TOTAL);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

  // controller states
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic             state_r, state_nxt;
  logic             act_r, act_nxt;
  num_t             num_r, num_nxt;
  count_t           count_r, count_nxt;

  // read issue side of the walk
  logic             iss_on_r, iss_on_nxt;
  logic [SW-1:0]    iss_slot_r, iss_slot_nxt;
  logic [BW-1:0]    iss_base_r, iss_base_nxt;

  // check side: the slot whose word arrives from the RAM this cycle
  logic             chk_v_r, chk_v_nxt;
  logic [SW-1:0]    chk_slot_r, chk_slot_nxt;
  logic [BW-1:0]    chk_base_r, chk_base_nxt;

  logic [SLOTS-1:0] slot_vld_r, slot_vld_nxt;

  logic             out_stb_r, out_stb_nxt;
  status_t          out_status_r, out_status_nxt;
  num_t             out_granted_r, out_granted_nxt;

  logic                 ram_we;
  logic [SLOT_BITS-1:0] ram_wdata;
  logic [SLOT_BITS-1:0] ram_rdata;

  logic                 accept;
  count_t               limit;
  logic [SLOT_BITS-1:0] word;
  logic                 zero_hit;
  logic [BIW-1:0]       zero_idx;
  logic [CW-1:0]        alloc_n;
  logic [CW-1:0]        rel_end;
  logic [CW-1:0]        rel_off;
  logic [BIW-1:0]       rel_bit;
  logic                 rel_hit;
  logic                 chk_last;

  bia_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (SLOTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk_slot_r),
    .wdata (ram_wdata),
    .re    (iss_on_r),
    .raddr (iss_slot_r),
    .rdata (ram_rdata)
  );

  assign accept = start && (state_r == S_IDLE);
  assign limit  = (count_r < TOTAL_CAP) ? count_r : TOTAL_CAP;

  // A slot never written since reset reads as all free.
  assign word = slot_vld_r[chk_slot_r] ? ram_rdata : '0;

  // Lowest clear bit of the slot word under check.
  always_comb begin
    zero_hit = 1'b0;
    zero_idx = '0;
    for (int i = SLOT_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        zero_hit = 1'b1;
        zero_idx = BIW'(i);
      end
    end
  end

  assign alloc_n  = CW'(chk_base_r) + CW'(zero_idx);
  assign rel_end  = CW'(chk_base_r) + CW'(SLOT_BITS);
  assign rel_hit  = CW'(num_r) < rel_end;
  assign rel_off  = CW'(num_r) - CW'(chk_base_r);
  assign rel_bit  = rel_off[BIW-1:0];
  assign chk_last = (chk_slot_r == LAST_SLOT);

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    num_nxt         = num_r;
    count_nxt       = count_r;
    iss_on_nxt      = iss_on_r;
    iss_slot_nxt    = iss_slot_r;
    iss_base_nxt    = iss_base_r;
    chk_v_nxt       = chk_v_r;
    chk_slot_nxt    = chk_slot_r;
    chk_base_nxt    = chk_base_r;
    slot_vld_nxt    = slot_vld_r;
    out_stb_nxt     = 1'b0;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    ram_we          = 1'b0;
    ram_wdata       = word;

    if (cfg_valid && cfg_ready) begin
      count_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt = in_action;
          num_nxt = in_number;
          if ((in_action == ACT_RELEASE) && (COUNT_W'(in_number) >= limit)) begin
            // out of range: answer at once, map untouched
            out_stb_nxt     = 1'b1;
            out_status_nxt  = ST_RANGE;
            out_granted_nxt = '0;
          end else begin
            state_nxt    = S_SCAN;
            iss_on_nxt   = 1'b1;
            iss_slot_nxt = '0;
            iss_base_nxt = '0;
            chk_v_nxt    = 1'b0;
          end
        end
      end

      S_SCAN: begin
        // advance the read walk; the check stage follows it in the next cycle
        chk_v_nxt    = iss_on_r;
        chk_slot_nxt = iss_slot_r;
        chk_base_nxt = iss_base_r;
        if (iss_on_r) begin
          if (iss_slot_r == LAST_SLOT) begin
            iss_on_nxt = 1'b0;
          end else begin
            iss_slot_nxt = iss_slot_r + SW'(1);
            iss_base_nxt = iss_base_r + BW'(SLOT_BITS);
          end
        end

        if (chk_v_r) begin
          if (act_r == ACT_ALLOC) begin
            if (zero_hit) begin
              out_stb_nxt = 1'b1;
              if (alloc_n >= CW'(limit)) begin
                out_status_nxt  = ST_FULL;
                out_granted_nxt = '0;
              end else begin
                ram_we          = 1'b1;
                ram_wdata       = word | (SLOT_BITS'(1) << zero_idx);
                out_status_nxt  = ST_DONE;
                out_granted_nxt = alloc_n[NUM_W-1:0];
              end
            end else if (chk_last) begin
              out_stb_nxt     = 1'b1;
              out_status_nxt  = ST_FULL;
              out_granted_nxt = '0;
            end
          end else begin
            if (rel_hit) begin
              out_stb_nxt     = 1'b1;
              out_granted_nxt = '0;
              if (!word[rel_bit]) begin
                out_status_nxt = ST_WAS_FREE;
              end else begin
                ram_we         = 1'b1;
                ram_wdata      = word & ~(SLOT_BITS'(1) << rel_bit);
                out_status_nxt = ST_DONE;
              end
            end else if (chk_last) begin
              // cannot happen after the range check; drop out cleanly
              out_stb_nxt     = 1'b1;
              out_status_nxt  = ST_RANGE;
              out_granted_nxt = '0;
            end
          end

          if (ram_we) begin
            slot_vld_nxt[chk_slot_r] = 1'b1;
          end
          if (out_stb_nxt) begin
            state_nxt  = S_IDLE;
            iss_on_nxt = 1'b0;
            chk_v_nxt  = 1'b0;
          end
        end
      end

      default: begin
        state_nxt  = S_IDLE;
        iss_on_nxt = 1'b0;
        chk_v_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= COUNT_RESET;
      iss_on_r   <= 1'b0;
      chk_v_r    <= 1'b0;
      slot_vld_r <= '0;
      out_stb_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      iss_on_r   <= iss_on_nxt;
      chk_v_r    <= chk_v_nxt;
      slot_vld_r <= slot_vld_nxt;
      out_stb_r  <= out_stb_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    num_r         <= num_nxt;
    iss_slot_r    <= iss_slot_nxt;
    iss_base_r    <= iss_base_nxt;
    chk_slot_r    <= chk_slot_nxt;
    chk_base_r    <= chk_base_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
  end

  assign busy        = (state_r == S_SCAN);
  assign cfg_ready   = (state_r == S_IDLE);
  assign out_strobe  = out_stb_r;
  assign out_status  = out_status_r;
  assign out_granted = out_granted_r;

endmodule

`default_nettype wire

// ===== src/bia_checker.sv =====
// Port-level checks of the bitmap id allocator, bound to the top level.
`default_nettype none

module bia_checker
  import bia_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                in_action,
  input wire logic [NUM_W-1:0]    in_number,
  input wire logic                out_strobe,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [NUM_W-1:0]    out_granted,
  input wire logic                cfg_valid,
  input wire logic                cfg_ready,
  input wire logic [COUNT_W-1:0]  cfg_data
);

  // a result only follows a request in flight or one just taken
  a_strobe_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy || start))
    else $error("result strobe without a request");

  // a failed request always carries a zero number
  a_granted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_DONE)) |-> (out_granted == '0))
    else $error("granted nonzero on a failed request");

  // an allocate always walks the map
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_action == ACT_ALLOC)) |=> busy)
    else $error("allocate taken without going busy");

  // the walk ends exactly with its result
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);

`default_nettype wire
